// ===== rtl/lcas_pkg.sv =====
// Shared types, constants and helpers of the life cellular automaton step unit.
package lcas_pkg;

    // Width of the size registers and of the position counters.
    localparam int SIZE_W = 7;
    // Largest value a size register can carry.
    localparam int SIZE_MAX = 2 ** SIZE_W - 1;
    // Default for the largest grid width the line buffers are built for.
    localparam int DEFAULT_MAX_WIDTH = 64;
    // Largest grid height.
    localparam int MAX_HEIGHT = 64;
    // Smallest grid width or height.
    localparam int MIN_SIZE = 3;
    // Reset value of both size registers before saturation.
    localparam int SIZE_RESET = 64;

    // Width of the reported coordinates.
    localparam int COORD_W = 6;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_IN_USE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_IN_USE = 1'b1;

    // Input kinds.
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Neighbour counts of the rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Which sides of the 3x3 window fall outside the grid.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge_flags;

    // Saturate a written size into MIN_SIZE..top.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                     input logic [SIZE_W-1:0] top);
        logic [SIZE_W-1:0] result;
        if (value < SIZE_W'(MIN_SIZE)) begin
            result = SIZE_W'(MIN_SIZE);
        end else if (value > top) begin
            result = top;
        end else begin
            result = value;
        end
        return result;
    endfunction

    // Number of set bits in a three-bit column.
    function automatic logic [1:0] ones3(input logic [2:0] v);
        return 2'({1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]});
    endfunction

endpackage

// ===== rtl/lcas_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module lcas_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read of the address being written returns
    // the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lcas_rule.sv =====
// Neighbour count over the 3x3 window and the birth and survival rule.
module lcas_rule
    import lcas_pkg::*;
(
    input  logic [8:0]   i_window,
    input  t_edge_flags  i_edges,
    output logic         o_next_alive
);

    logic [2:0] row_mask;
    logic [2:0] left_col;
    logic [2:0] mid_col;
    logic [2:0] right_col;
    logic [3:0] count;
    logic       centre;

    // Bit 0 of each column is the row above, bit 2 the row below.
    always_comb begin
        row_mask  = {~i_edges.bottom, 1'b1, ~i_edges.top};
        left_col  = i_edges.left  ? 3'b000 : (i_window[8:6] & row_mask);
        right_col = i_edges.right ? 3'b000 : (i_window[2:0] & row_mask);
        // The centre cell itself is no neighbour.
        mid_col   = i_window[5:3] & row_mask & 3'b101;
        centre    = i_window[4];
        count     = 4'(ones3(left_col)) + 4'(ones3(mid_col)) + 4'(ones3(right_col));
    end

    // Born on three neighbours, survives on two or three.
    assign o_next_alive = (count == BIRTH_COUNT) || (centre && (count == SURVIVE_COUNT));

endmodule

// ===== rtl/life_cellular_automaton_step_unit.sv =====
// Top level of the life cellular automaton step unit: one generation, streamed.
//
// Cells of one generation arrive in raster order on the slave stream, one per beat:
// tuser is the kind (0 cell, 1 drain) and tdata bit 0 the cell state. For every cell
// that completes a 3x3 neighbourhood the master stream carries the next-generation
// state of the cell one row and one column behind, with its row and column; tlast
// marks the last cell of the generation. After the last cell of a frame, width+1
// drain beats flush the remaining results. Cells outside the grid count as dead.
// The grid size is set through the write port (index 0 width, index 1 height);
// a write restarts the frame at cell (0,0). Writes are made only while the unit is idle;
// the user must keep to this, as the unit does not enforce it. Throughput is one beat per
// cycle while the receiver does not stall: the line buffers are one RAM read ahead of the
// column counter, and the rule is evaluated straight into the output register.
// A result waits in the output register while the receiver stalls; a new beat is
// taken in the same cycle as the waiting one is taken.
// Reset sets both sizes to 64 (width saturated to MAX_WIDTH) and the position
// counters to zero; line buffer contents need no clearing as they are always
// rewritten before they can reach a result.
module life_cellular_automaton_step_unit
    import lcas_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]      i_cfg_wdata,
    // Cell stream in.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [0] alive, [7:1] zero
    input  logic                   i_s_axis_tuser,   // [0] kind
    // Result stream out.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [15:0]            o_m_axis_tdata,   // [0] next_alive, [6:1] out_row,
                                                     // [12:7] out_col, [15:13] zero
    output logic                   o_m_axis_tlast    // frame_last
);

    // Width cannot exceed what the register carries.
    localparam int EFF_WIDTH = (MAX_WIDTH < SIZE_MAX) ? MAX_WIDTH : SIZE_MAX;
    localparam int ADDR_W    = $clog2(EFF_WIDTH);
    localparam logic [SIZE_W-1:0] WIDTH_TOP   = SIZE_W'(EFF_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_TOP  = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] WIDTH_RESET =
        SIZE_W'((EFF_WIDTH < SIZE_RESET) ? EFF_WIDTH : SIZE_RESET);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(SIZE_RESET);

    logic [SIZE_W-1:0]  r_width, n_width;
    logic [SIZE_W-1:0]  r_height, n_height;
    logic [SIZE_W-1:0]  r_in_col, n_in_col;
    logic [SIZE_W-1:0]  r_in_row, n_in_row;
    logic [SIZE_W-1:0]  r_out_col, n_out_col;
    logic [SIZE_W-1:0]  r_out_row, n_out_row;
    logic [8:0]         r_window, n_window;

    logic               r_out_valid;
    logic               r_next_alive;
    logic [COORD_W-1:0] r_out_row_q;
    logic [COORD_W-1:0] r_out_col_q;
    logic               r_frame_last;

    logic               in_accept;
    logic               draining;
    logic               step_en;
    logic               cell_value;
    logic               result_ready;
    logic               is_last;
    logic [1:0]         buf_rd_data;
    logic [1:0]         buf_wr_data;
    logic [ADDR_W-1:0]  buf_rd_addr;
    logic [SIZE_W-1:0]  in_col_inc;
    logic [SIZE_W-1:0]  out_col_inc;
    logic [SIZE_W-1:0]  out_row_inc;
    t_edge_flags        edges;
    logic               rule_next_alive;

    // Take a beat whenever the output register is free or is emptied now.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Past the last grid row every beat counts as a dead drain cell; before it,
    // drain beats are dropped.
    assign draining   = r_in_row >= r_height;
    assign step_en    = in_accept && (draining || (i_s_axis_tuser == KIND_CELL));
    assign cell_value = draining ? 1'b0 : i_s_axis_tdata[0];

    assign in_col_inc  = r_in_col + SIZE_W'(1);
    assign out_col_inc = r_out_col + SIZE_W'(1);
    assign out_row_inc = r_out_row + SIZE_W'(1);

    // A neighbourhood is complete once the input is one row and one column ahead.
    assign result_ready = (r_in_row >= SIZE_W'(2)) ||
                          ((r_in_row == SIZE_W'(1)) && (r_in_col != '0));

    assign edges.top    = (r_out_row == '0);
    assign edges.bottom = (out_row_inc >= r_height);
    assign edges.left   = (r_out_col == '0);
    assign edges.right  = (out_col_inc >= r_width);
    assign is_last      = edges.bottom && edges.right;

    // Bit 1 holds the row two above the input, bit 0 the row just above it.
    assign buf_wr_data = {buf_rd_data[0], cell_value};

    // Size registers, position counters and window.
    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_window  = r_window;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH_IN_USE:  n_width  = clamp_size(i_cfg_wdata, WIDTH_TOP);
                REG_HEIGHT_IN_USE: n_height = clamp_size(i_cfg_wdata, HEIGHT_TOP);
                default:           n_width  = r_width;
            endcase
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (step_en) begin
            n_window = {r_window[5:0], cell_value, buf_rd_data[0], buf_rd_data[1]};
            if (in_col_inc >= r_width) begin
                n_in_col = '0;
                n_in_row = r_in_row + SIZE_W'(1);
            end else begin
                n_in_col = in_col_inc;
            end
            if (result_ready) begin
                if (is_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_inc >= r_width) begin
                    n_out_col = '0;
                    n_out_row = out_row_inc;
                end else begin
                    n_out_col = out_col_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_window  <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_window  <= n_window;
        end
    end

    // Line buffers: the read is issued for the column the next beat will use.
    assign buf_rd_addr = i_rst_n ? n_in_col[ADDR_W-1:0] : '0;

    lcas_ram #(
        .WIDTH (2),
        .DEPTH (EFF_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_we      (step_en),
        .i_wr_addr (r_in_col[ADDR_W-1:0]),
        .i_wr_data (buf_wr_data),
        .i_rd_addr (buf_rd_addr),
        .o_rd_data (buf_rd_data)
    );

    // Rule on the window as it stands after this beat is shifted in.
    lcas_rule u_rule (
        .i_window     (n_window),
        .i_edges      (edges),
        .o_next_alive (rule_next_alive)
    );

    // Output register: valid state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en && result_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge i_clk) begin
        if (step_en && result_ready) begin
            r_next_alive <= rule_next_alive;
            r_out_row_q  <= r_out_row[COORD_W-1:0];
            r_out_col_q  <= r_out_col[COORD_W-1:0];
            r_frame_last <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_col_q, r_out_row_q, r_next_alive};
    assign o_m_axis_tlast  = r_frame_last;

endmodule

// ===== dv/life_cellular_automaton_step_unit_test.sv =====
// Self-checking testbench of the life cellular automaton step unit.
module life_cellular_automaton_step_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcas_pkg::*;

    // Generous bound on the run, far above the slowest correct run.
    localparam int CYCLE_LIMIT = 400_000;
    // Cells plus flush beats that the stimulus aims for.
    localparam int TARGET_BEATS = 1900;

    typedef struct packed {
        logic kind;
        logic alive;
    } t_cell_beat;

    typedef struct packed {
        logic       next_alive;
        logic [5:0] row;
        logic [5:0] col;
        logic       frame_last;
    } t_life_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]      i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata;   // [0] alive, [7:1] zero
    logic                   i_s_axis_tuser;   // [0] kind
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [15:0]            o_m_axis_tdata;   // [0] next_alive, [6:1] out_row,
                                              // [12:7] out_col, [15:13] zero
    logic                   o_m_axis_tlast;   // frame_last

    // Stimulus waiting for the driver, and the next-generation states still owed.
    t_cell_beat   cell_queue[$];
    t_life_result next_states[$];

    // Own copy of the grid size and of the streaming state.
    logic [SIZE_W-1:0] grid_width;
    logic [SIZE_W-1:0] grid_height;
    logic              line_above[DEFAULT_MAX_WIDTH];
    logic              line_current[DEFAULT_MAX_WIDTH];
    logic [8:0]        nbr_window;
    int unsigned       in_col, in_row, out_col, out_row;

    bit cell_beat_taken;
    bit calm;
    int cycle_count;
    int bad_results;
    int stimulus_beats;

    life_cellular_automaton_step_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Shift one accepted beat through the line buffers and the window, and
    // record the next state of the cell one row and one column behind.
    task automatic advance_generation(input logic kind, input logic alive);
        logic         draining, v, above, cur, ready, centre, last;
        logic [2:0]   left, mid, right, rowmask;
        int unsigned  n;
        t_life_result r;
        draining = (in_row >= grid_height);
        // A drain before the grid is complete changes nothing.
        if (!draining && kind == KIND_DRAIN) return;
        v = draining ? 1'b0 : alive;
        above = line_above[in_col];
        cur = line_current[in_col];
        line_above[in_col] = cur;
        line_current[in_col] = v;
        nbr_window = {nbr_window[5:0], v, cur, above};
        ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= grid_width) begin
            in_col = 0;
            in_row++;
        end
        if (!ready) return;

        // Rows and columns outside the grid count as dead.
        rowmask = 3'b111;
        if (out_row == 0) rowmask[0] = 1'b0;
        if (out_row + 1 >= grid_height) rowmask[2] = 1'b0;
        left = nbr_window[8:6];
        mid = nbr_window[5:3];
        right = nbr_window[2:0];
        centre = mid[1];
        if (out_col == 0) left = 3'b000;
        if (out_col + 1 >= grid_width) right = 3'b000;
        left &= rowmask;
        mid &= rowmask & 3'b101;
        right &= rowmask;
        n = 0;
        for (int b = 0; b < 3; b++) begin
            n += left[b] + mid[b] + right[b];
        end

        last = (out_row + 1 >= grid_height) && (out_col + 1 >= grid_width);
        r.next_alive = (n == BIRTH_COUNT) || (centre && n == SURVIVE_COUNT);
        r.row = 6'(out_row);
        r.col = 6'(out_col);
        r.frame_last = last;
        next_states.push_back(r);

        if (last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= grid_width) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic queue_beat(input logic kind, input logic alive);
        t_cell_beat beat;
        beat.kind = kind;
        beat.alive = alive;
        cell_queue.push_back(beat);
    endtask

    // Wait until no beat is pending or in flight and every result has come,
    // then give the unit time to finish internally.
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (cell_queue.size() != 0 || i_s_axis_tvalid || next_states.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // A size write also restarts the frame at cell (0,0).
    task automatic write_size(input logic [CFG_INDEX_W-1:0] index,
                              input logic [SIZE_W-1:0] value);
        logic [SIZE_W-1:0] held;
        if (value < MIN_SIZE) begin
            held = SIZE_W'(MIN_SIZE);
        end else if (value > DEFAULT_MAX_WIDTH) begin
            held = SIZE_W'(DEFAULT_MAX_WIDTH);
        end else begin
            held = value;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        if (index == REG_WIDTH_IN_USE) begin
            grid_width = held;
        end else begin
            grid_height = held;
        end
        restart_frame();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One generation at the current size; stop_after below the cell count
    // leaves the frame unfinished. Noisy frames carry drains among the cells,
    // cells among the flush beats and drains after the end.
    task automatic queue_frame(input int density, input bit noisy, input int stop_after);
        int cells;
        cells = grid_width * grid_height;
        for (int k = 0; k < cells && k < stop_after; k++) begin
            if (noisy && $urandom_range(0, 9) == 0) queue_beat(KIND_DRAIN, 1'($urandom));
            queue_beat(KIND_CELL, $urandom_range(0, 99) < density);
            stimulus_beats++;
        end
        if (stop_after < cells) return;
        for (int k = 0; k <= grid_width; k++) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                queue_beat(KIND_CELL, 1'($urandom));
            end else begin
                queue_beat(KIND_DRAIN, 1'($urandom));
            end
        end
        stimulus_beats += grid_width + 1;
        if (noisy) begin
            repeat ($urandom_range(1, 3)) queue_beat(KIND_DRAIN, 1'($urandom));
        end
    endtask

    // Driver and receiver back-pressure, both changing on the falling edge.
    always @(negedge i_clk) begin
        t_cell_beat beat;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || cell_beat_taken) begin
                if (cell_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
                    beat = cell_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= beat.kind;
                    i_s_axis_tdata <= {7'b0, beat.alive};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= calm || $urandom_range(0, 99) >= 26;
        end
    end

    // Prediction on each input beat, then the check of each result beat.
    always @(posedge i_clk) begin
        t_life_result seen, want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("life_cellular_automaton_step_unit regression: fail");
            $finish;
        end else if (i_rst_n) begin
            cell_beat_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                advance_generation(i_s_axis_tuser, i_s_axis_tdata[0]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.next_alive = o_m_axis_tdata[0];
                seen.row = o_m_axis_tdata[6:1];
                seen.col = o_m_axis_tdata[12:7];
                seen.frame_last = o_m_axis_tlast;
                if (next_states.size() == 0) begin
                    $error("result beat with nothing expected: row %0d col %0d",
                           seen.row, seen.col);
                    bad_results++;
                end else begin
                    want = next_states.pop_front();
                    if (seen.next_alive !== want.next_alive) begin
                        $error("next_alive: expected %0d, actual %0d",
                               want.next_alive, seen.next_alive);
                        bad_results++;
                    end
                    if (seen.row !== want.row) begin
                        $error("out_row: expected %0d, actual %0d", want.row, seen.row);
                        bad_results++;
                    end
                    if (seen.col !== want.col) begin
                        $error("out_col: expected %0d, actual %0d", want.col, seen.col);
                        bad_results++;
                    end
                    if (seen.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0d, actual %0d",
                               want.frame_last, seen.frame_last);
                        bad_results++;
                    end
                end
            end
        end
    end

    // Reset, a directed opening, then random frames at changing sizes.
    initial begin
        int  raw_w, raw_h, cells, stop_at, frame_no, r;
        bit  abandon;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WIDTH_IN_USE;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = KIND_CELL;
        i_m_axis_tready = 1'b0;
        grid_width = SIZE_W'(SIZE_RESET);
        grid_height = SIZE_W'(SIZE_RESET);
        nbr_window = '0;
        restart_frame();
        for (int k = 0; k < DEFAULT_MAX_WIDTH; k++) begin
            line_above[k] = 1'b0;
            line_current[k] = 1'b0;
        end
        calm = 1'b0;
        cycle_count = 0;
        bad_results = 0;
        stimulus_beats = 0;
        cell_beat_taken = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest grid via sizes below the minimum, fully alive: corners
        // survive, edges and centre die of crowding. A drain before any cell,
        // one in mid-frame, a cell in the flush and a drain after the end.
        write_size(REG_WIDTH_IN_USE, '0);
        write_size(REG_HEIGHT_IN_USE, SIZE_W'(2));
        queue_beat(KIND_DRAIN, 1'b1);
        for (int k = 0; k < 9; k++) begin
            if (k == 4) queue_beat(KIND_DRAIN, 1'b1);
            queue_beat(KIND_CELL, 1'b1);
        end
        repeat (3) queue_beat(KIND_DRAIN, 1'b0);
        queue_beat(KIND_CELL, 1'b1);
        queue_beat(KIND_DRAIN, 1'b1);
        // Part of a frame, abandoned by the next size write.
        repeat (5) queue_beat(KIND_CELL, 1'($urandom));
        wait_quiet();
        write_size(REG_WIDTH_IN_USE, SIZE_W'(SIZE_MAX));
        write_size(REG_HEIGHT_IN_USE, SIZE_W'(3));

        frame_no = 0;
        abandon = 1'b1;
        while (stimulus_beats < TARGET_BEATS) begin
            calm = (frame_no >= 12 && frame_no < 18);
            if (frame_no < 2 || abandon || $urandom_range(0, 1) == 1) begin
                wait_quiet();
                if (frame_no == 0) begin
                    raw_w = DEFAULT_MAX_WIDTH;
                    raw_h = MIN_SIZE;
                end else if (frame_no == 1) begin
                    raw_w = MIN_SIZE;
                    raw_h = MAX_HEIGHT;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70) raw_w = $urandom_range(3, 9);
                    else if (r < 80) raw_w = $urandom_range(0, 2);
                    else if (r < 90) raw_w = $urandom_range(10, 48);
                    else raw_w = $urandom_range(65, SIZE_MAX);
                    // Keep wide grids short so that frames stay small.
                    r = $urandom_range(0, 99);
                    if (raw_w > 12) raw_h = $urandom_range(0, 5);
                    else if (r < 75) raw_h = $urandom_range(3, 9);
                    else if (r < 85) raw_h = $urandom_range(0, 2);
                    else if (raw_w <= 4) raw_h = $urandom_range(65, SIZE_MAX);
                    else raw_h = $urandom_range(10, 20);
                end
                if ($urandom_range(0, 1) == 1) begin
                    write_size(REG_WIDTH_IN_USE, SIZE_W'(raw_w));
                    write_size(REG_HEIGHT_IN_USE, SIZE_W'(raw_h));
                end else begin
                    write_size(REG_HEIGHT_IN_USE, SIZE_W'(raw_h));
                    write_size(REG_WIDTH_IN_USE, SIZE_W'(raw_w));
                end
            end
            cells = grid_width * grid_height;
            abandon = (frame_no >= 2 && $urandom_range(0, 9) == 0);
            stop_at = abandon ? $urandom_range(1, cells - 1) : cells;
            queue_frame($urandom_range(0, 100), $urandom_range(0, 4) == 0, stop_at);
            frame_no++;
        end

        wait_quiet();
        repeat (8) @(negedge i_clk);
        if (next_states.size() != 0) begin
            $error("%0d next-generation results never arrived", next_states.size());
            bad_results++;
        end
        if (bad_results == 0) begin
            $display("life_cellular_automaton_step_unit regression: pass");
        end else begin
            $display("life_cellular_automaton_step_unit regression: fail");
        end
        $finish;
    end

endmodule
